@@ sv/assert_macros.svh @@
// Assertion helpers for the segment intersection classifier
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// check that a condition implies another in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

@@ sv/sic_pkg.sv @@
// ----------------------------------------------------------------------------
// sic_pkg
// Shared constants and types for the segment intersection classifier.
// ----------------------------------------------------------------------------
package sic_pkg;
	localparam int unsigned COORD_WIDTH_DEF = 16;
	localparam int unsigned CLASS_W = 3;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW = 2;

	typedef enum logic [CLASS_W-1:0] {
		CLS_NONE     = 3'd0,
		CLS_ENDPOINT = 3'd1,
		CLS_CROSS    = 3'd2,
		CLS_TOUCH    = 3'd3,
		CLS_OVERLAP  = 3'd4
	} contact_class_t;

	// case selected by the front end
	typedef enum logic [2:0] {
		K_NONE     = 3'd0,
		K_PT_AB    = 3'd1,
		K_PT_CD    = 3'd2,
		K_PAR      = 3'd3,
		K_SPAN     = 3'd4,
		K_SLOPED   = 3'd5,
		K_CROSS    = 3'd6
	} kind_t;
endpackage

@@ sv/sic_front.sv @@
// ----------------------------------------------------------------------------
// sic_front
// Two-stage front end: differences and products, then cross products, case
// selection and registered flags, resolved to a class word pushed into the queue.
// ----------------------------------------------------------------------------
module sic_front #(
	parameter int unsigned COORD_WIDTH = sic_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic signed [COORD_WIDTH-1:0] ax, ay, bx, by, cx, cy, dx, dy,
	output logic out_valid,
	output logic [sic_pkg::CLASS_W-1:0] out_class
);
	import sic_pkg::*;

	localparam int unsigned DW = COORD_WIDTH + 1;
	localparam int unsigned PW = 2 * DW;
	localparam int unsigned XW = PW + 1;

	typedef logic signed [DW-1:0] dif_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [XW-1:0] crs_t;

	// widened operands
	dif_t eax, eay, ebx, eby, ecx, ecy, edx, edy;
	assign eax = DW'(ax); assign eay = DW'(ay);
	assign ebx = DW'(bx); assign eby = DW'(by);
	assign ecx = DW'(cx); assign ecy = DW'(cy);
	assign edx = DW'(dx); assign edy = DW'(dy);

	dif_t abx, aby, cdx, cdy, acx, acy;
	assign abx = ebx - eax; assign aby = eby - eay;
	assign cdx = edx - ecx; assign cdy = edy - ecy;
	assign acx = ecx - eax; assign acy = ecy - eay;

	// stage 1 registers: products and coordinates
	logic valid_s1;
	prod_t p_d1_s1, p_d2_s1, p_s1_s1, p_s2_s1, p_r1_s1, p_r2_s1;
	prod_t q_c1_s1, q_c2_s1, q_a1_s1, q_a2_s1;
	dif_t ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1, dx_s1, dy_s1;

	// compute the six products for d, sn, rn and four more for the point-on-line tests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		p_d1_s1 <= abx * cdy;
		p_d2_s1 <= aby * cdx;
		p_s1_s1 <= acx * aby;
		p_s2_s1 <= acy * abx;
		p_r1_s1 <= acx * cdy;
		p_r2_s1 <= acy * cdx;
		// point A against CD, point C against AB
		q_c1_s1 <= (eax - ecx) * cdy;
		q_c2_s1 <= (eay - ecy) * cdx;
		q_a1_s1 <= acx * aby;
		q_a2_s1 <= acy * abx;
		ax_s1 <= eax; ay_s1 <= eay; bx_s1 <= ebx; by_s1 <= eby;
		cx_s1 <= ecx; cy_s1 <= ecy; dx_s1 <= edx; dy_s1 <= edy;
	end

	// stage 2: form cross products, normalize sign
	crs_t d_w, sn_w, rn_w, d_n, sn_n, rn_n, qa_w, qc_w;
	assign d_w  = XW'(p_d1_s1) - XW'(p_d2_s1);
	assign sn_w = XW'(p_s1_s1) - XW'(p_s2_s1);
	assign rn_w = XW'(p_r1_s1) - XW'(p_r2_s1);
	assign qc_w = XW'(q_c1_s1) - XW'(q_c2_s1);
	assign qa_w = XW'(q_a1_s1) - XW'(q_a2_s1);
	assign d_n  = d_w[XW-1] ? -d_w : d_w;
	assign sn_n = d_w[XW-1] ? -sn_w : sn_w;
	assign rn_n = d_w[XW-1] ? -rn_w : rn_w;

	logic valid_s2;
	kind_t kind_s2;
	logic r0_s2, r1_s2, rin_s2, s0_s2, s1_s2, sin_s2;
	logic [2:0] pt_s2, span_s2, slope_s2;

	// spans helpers
	function automatic logic [2:0] span_f(dif_t a0, dif_t a1, dif_t c0, dif_t c1);
		dif_t amx, amn, cmx, cmn;
		amx = (a0 > a1) ? a0 : a1; amn = (a0 < a1) ? a0 : a1;
		cmx = (c0 > c1) ? c0 : c1; cmn = (c0 < c1) ? c0 : c1;
		if (amx >= cmn && amn <= cmx) begin
			if (amx == cmn || amn == cmx) return CLS_ENDPOINT;
			return CLS_OVERLAP;
		end
		return CLS_NONE;
	endfunction

	function automatic logic [2:0] pt_f(dif_t px, dif_t py, dif_t ex, dif_t ey,
			dif_t fx, dif_t fy, logic online);
		dif_t xmn, xmx, ymn, ymx;
		xmn = (ex < fx) ? ex : fx; xmx = (ex > fx) ? ex : fx;
		ymn = (ey < fy) ? ey : fy; ymx = (ey > fy) ? ey : fy;
		if (ex == fx) begin
			if (px == ex && (py == ey || py == fy)) return CLS_ENDPOINT;
			if (px == ex && ymn <= py && ymx >= py) return CLS_CROSS;
			return CLS_NONE;
		end
		if (ey == fy) begin
			if (py == ey && (px == ex || px == fx)) return CLS_ENDPOINT;
			if (py == ey && xmn <= px && xmx >= px) return CLS_CROSS;
			return CLS_NONE;
		end
		if (!online) return CLS_NONE;
		if (px == ex || px == fx) return CLS_ENDPOINT;
		if (xmn < px && px < xmx) return CLS_CROSS;
		return CLS_NONE;
	endfunction

	logic ab0, cd0, shared, xsep, xovl;
	dif_t abmn, abmx, cdmn, cdmx;
	always_comb begin
		ab0 = (ax_s1 == bx_s1) && (ay_s1 == by_s1);
		cd0 = (cx_s1 == dx_s1) && (cy_s1 == dy_s1);
		abmn = (ax_s1 < bx_s1) ? ax_s1 : bx_s1; abmx = (ax_s1 > bx_s1) ? ax_s1 : bx_s1;
		cdmn = (cx_s1 < dx_s1) ? cx_s1 : dx_s1; cdmx = (cx_s1 > dx_s1) ? cx_s1 : dx_s1;
		shared = (ax_s1 == cx_s1 && ay_s1 == cy_s1) || (ax_s1 == dx_s1 && ay_s1 == dy_s1)
			|| (bx_s1 == cx_s1 && by_s1 == cy_s1) || (bx_s1 == dx_s1 && by_s1 == dy_s1);
		xsep = (abmx <= cdmn) || (abmn >= cdmx);
		xovl = (abmn < cdmx) && (abmx > cdmn);
	end

	// select the case and register the flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		pt_s2 <= ab0 ? pt_f(ax_s1, ay_s1, cx_s1, cy_s1, dx_s1, dy_s1, qc_w == '0)
			: pt_f(cx_s1, cy_s1, ax_s1, ay_s1, bx_s1, by_s1, qa_w == '0);
		span_s2 <= (ay_s1 == cy_s1) ? span_f(ax_s1, bx_s1, cx_s1, dx_s1)
			: span_f(ay_s1, by_s1, cy_s1, dy_s1);
		slope_s2 <= (shared && xsep) ? CLS_ENDPOINT : (xovl ? CLS_OVERLAP : CLS_NONE);
		r0_s2 <= (rn_n == '0); r1_s2 <= (rn_n == d_n);
		rin_s2 <= !rn_n[XW-1] && rn_n != '0 && rn_n < d_n;
		s0_s2 <= (sn_n == '0); s1_s2 <= (sn_n == d_n);
		sin_s2 <= !sn_n[XW-1] && sn_n != '0 && sn_n < d_n;
		if (ab0 && cd0) kind_s2 <= K_NONE;
		else if (ab0 || cd0) kind_s2 <= K_PT_AB;
		else if (d_w == '0) begin
			if (sn_w != '0) kind_s2 <= K_PAR;
			else if (ay_s1 == cy_s1 || ax_s1 == bx_s1) kind_s2 <= K_SPAN;
			else kind_s2 <= K_SLOPED;
		end else kind_s2 <= K_CROSS;
	end

	// resolve the class from the registered flags
	logic re, se;
	always_comb begin
		re = r0_s2 || r1_s2;
		se = s0_s2 || s1_s2;
		out_valid = valid_s2;
		unique case (kind_s2)
			K_PT_AB, K_PT_CD: out_class = pt_s2;
			K_SPAN:           out_class = span_s2;
			K_SLOPED:         out_class = slope_s2;
			K_CROSS: begin
				if (re && se) out_class = CLS_ENDPOINT;
				else if ((se && rin_s2) || (re && sin_s2)) out_class = CLS_TOUCH;
				else if (rin_s2 && sin_s2) out_class = CLS_CROSS;
				else out_class = CLS_NONE;
			end
			default: out_class = CLS_NONE;
		endcase
	end
endmodule

@@ sv/sic_back.sv @@
// ----------------------------------------------------------------------------
// sic_back
// Result queue and output register: buffers classified words and shows
// each on the result ports for one cycle.
// ----------------------------------------------------------------------------
module sic_back (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [sic_pkg::CLASS_W-1:0] push_class,
	output logic strobe,
	output logic [sic_pkg::CLASS_W-1:0] contact_class,
	output logic [sic_pkg::QUEUE_AW:0] level
);
	import sic_pkg::*;

	logic [CLASS_W-1:0] mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q, rd_q;
	logic [QUEUE_AW:0] cnt_q;
	logic pop;

	assign pop = (cnt_q != '0);
	assign level = cnt_q;

	// store words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_class;
		end
	end

	// advance pointers and present one word a cycle while the queue is not empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			strobe <= 1'b0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
			strobe <= pop;
		end
	end

	always_ff @(posedge clk) begin
		contact_class <= mem_q[rd_q];
	end
endmodule

@@ sv/segment_intersection_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_classifier_unit
// Exact contact classification of two integer line segments.
// ----------------------------------------------------------------------------
// A word is taken on every cycle with start high and busy low; busy stays low
// in normal use, so one pair of segments may enter every cycle. The class
// appears on contact_class with strobe high for one cycle, after the word has
// passed the two front stages of products and case selection, a queue write
// and the output register, the first stage loading on the accepting edge
// itself. The receiver cannot stall.
`include "assert_macros.svh"
module segment_intersection_classifier_unit #(
	parameter int unsigned COORD_WIDTH = sic_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [COORD_WIDTH-1:0] seg1_start_x,
	input  logic signed [COORD_WIDTH-1:0] seg1_start_y,
	input  logic signed [COORD_WIDTH-1:0] seg1_end_x,
	input  logic signed [COORD_WIDTH-1:0] seg1_end_y,
	input  logic signed [COORD_WIDTH-1:0] seg2_start_x,
	input  logic signed [COORD_WIDTH-1:0] seg2_start_y,
	input  logic signed [COORD_WIDTH-1:0] seg2_end_x,
	input  logic signed [COORD_WIDTH-1:0] seg2_end_y,
	output logic strobe,
	output logic [sic_pkg::CLASS_W-1:0] contact_class
);
	import sic_pkg::*;

	logic accept, f_valid;
	logic [CLASS_W-1:0] f_class;
	logic [QUEUE_AW:0] level;

	// queue drains one word a cycle, so it never fills
	assign busy = (level == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign accept = start && !busy;

	sic_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(accept),
		.ax(seg1_start_x), .ay(seg1_start_y), .bx(seg1_end_x), .by(seg1_end_y),
		.cx(seg2_start_x), .cy(seg2_start_y), .dx(seg2_end_x), .dy(seg2_end_y),
		.out_valid(f_valid), .out_class(f_class)
	);

	sic_back u_back (
		.clk(clk), .arst_n(arst_n), .push(f_valid), .push_class(f_class),
		.strobe(strobe), .contact_class(contact_class), .level(level)
	);

	`ASSERT_IMPLIES(a_class_range, clk, arst_n, strobe, contact_class <= CLS_OVERLAP)
	`ASSERT_IMPLIES(a_level_max, clk, arst_n, 1'b1, level <= 2)
	`ASSERT_NEXT(a_queue_drains, clk, arst_n, level != 0, strobe)
endmodule

@@ bench/tb_segment_intersection_classifier_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_intersection_classifier_unit
// Drives pairs of segments into the classifier and checks every class word
// against an exact integer prediction of the contact tree, in order.
// ----------------------------------------------------------------------------
module tb_segment_intersection_classifier_unit;
	import sic_pkg::*;

	localparam int CW = 16;
	typedef logic signed [CW-1:0] coord_t;
	typedef struct {
		coord_t ax, ay, bx, by, cx, cy, dx, dy;
	} seg_pair_t;

	// Order-preserving store of predicted contact classes.
	class contact_scoreboard;
		contact_class_t pending[$];
		int errors = 0;

		static function longint lmax(longint a, longint b);
			return a > b ? a : b;
		endfunction
		static function longint lmin(longint a, longint b);
			return a < b ? a : b;
		endfunction

		static function contact_class_t point_on(longint px, longint py, longint ex,
			longint ey, longint fx, longint fy);
			if (ex == fx) begin
				if (px == ex && (py == ey || py == fy)) return CLS_ENDPOINT;
				if (px == ex && lmin(ey, fy) <= py && lmax(ey, fy) >= py) return CLS_CROSS;
				return CLS_NONE;
			end
			if (ey == fy) begin
				if (py == ey && (px == ex || px == fx)) return CLS_ENDPOINT;
				if (py == ey && lmin(ex, fx) <= px && lmax(ex, fx) >= px) return CLS_CROSS;
				return CLS_NONE;
			end
			if ((px - ex) * (fy - ey) - (py - ey) * (fx - ex) != 0) return CLS_NONE;
			if (px == ex || px == fx) return CLS_ENDPOINT;
			if (lmin(ex, fx) < px && px < lmax(ex, fx)) return CLS_CROSS;
			return CLS_NONE;
		endfunction

		static function contact_class_t spans(longint a0, longint a1, longint c0,
			longint c1);
			if (lmax(a0, a1) >= lmin(c0, c1) && lmin(a0, a1) <= lmax(c0, c1)) begin
				if (lmax(a0, a1) == lmin(c0, c1) || lmin(a0, a1) == lmax(c0, c1))
					return CLS_ENDPOINT;
				return CLS_OVERLAP;
			end
			return CLS_NONE;
		endfunction

		// 0 at zero, 1 at one, 2 inside, 3 outside (den > 0)
		static function int param_place(longint num, longint den);
			if (num == 0) return 0;
			if (num == den) return 1;
			if (num > 0 && num < den) return 2;
			return 3;
		endfunction

		static function contact_class_t classify(seg_pair_t p);
			longint ax, ay, bx, by, cx, cy, dx, dy, den, rn, sn;
			int rc, sc;
			bit re, se, ab0, cd0;
			ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
			cx = p.cx; cy = p.cy; dx = p.dx; dy = p.dy;
			ab0 = (ax == bx && ay == by);
			cd0 = (cx == dx && cy == dy);
			if (ab0 && cd0) return CLS_NONE;
			if (ab0) return point_on(ax, ay, cx, cy, dx, dy);
			if (cd0) return point_on(cx, cy, ax, ay, bx, by);
			den = (bx - ax) * (dy - cy) - (by - ay) * (dx - cx);
			sn = (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
			if (den == 0) begin
				if (sn != 0) return CLS_NONE;
				if (ay == cy) return spans(ax, bx, cx, dx);
				if (ax == bx) return spans(ay, by, cy, dy);
				if (((ax == cx && ay == cy) || (ax == dx && ay == dy) ||
					(bx == cx && by == cy) || (bx == dx && by == dy)) &&
					(lmax(ax, bx) <= lmin(cx, dx) || lmin(ax, bx) >= lmax(cx, dx)))
					return CLS_ENDPOINT;
				if (lmin(ax, bx) < lmax(cx, dx) && lmax(ax, bx) > lmin(cx, dx))
					return CLS_OVERLAP;
				return CLS_NONE;
			end
			rn = (cx - ax) * (dy - cy) - (cy - ay) * (dx - cx);
			if (den < 0) begin
				den = -den; rn = -rn; sn = -sn;
			end
			rc = param_place(rn, den);
			sc = param_place(sn, den);
			re = (rc <= 1);
			se = (sc <= 1);
			if (re && se) return CLS_ENDPOINT;
			if ((se && rc == 2) || (re && sc == 2)) return CLS_TOUCH;
			if (rc == 2 && sc == 2) return CLS_CROSS;
			return CLS_NONE;
		endfunction

		function void note_pair(seg_pair_t p);
			pending.push_back(classify(p));
		endfunction

		function void check_class(logic [CLASS_W-1:0] got);
			contact_class_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected class word, expected none, actual %0d", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$display("%0t: contact_class mismatch, expected %0d, actual %0d",
					$time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, strobe;
	logic [CLASS_W-1:0] contact_class;
	seg_pair_t drv = '{default: '0};
	contact_scoreboard sb = new();
	int send_idle_pct = 0;
	int stall_count = 0;

	segment_intersection_classifier_unit #(.COORD_WIDTH(CW)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.seg1_start_x(drv.ax), .seg1_start_y(drv.ay),
		.seg1_end_x(drv.bx), .seg1_end_y(drv.by),
		.seg2_start_x(drv.cx), .seg2_start_y(drv.cy),
		.seg2_end_x(drv.dx), .seg2_end_y(drv.dy),
		.strobe(strobe), .contact_class(contact_class)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Monitor: note accepted words and check class words at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) sb.note_pair(drv);
			if (strobe) sb.check_class(contact_class);
			if ((start && !busy) || strobe) stall_count <= 0;
			else stall_count <= stall_count + 1;
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if (stall_count > 5000) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Send one word from a falling edge: optional idle gap, then hold start
	// until accepted. Returns at the next falling edge with start still high,
	// so the following word can go out back to back.
	task automatic send_pair(seg_pair_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		drv <= p;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	// Drop start and wait for every expected word, ending on a falling edge.
	task automatic drain_all();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 14)) - coord_t'(7);
			default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
		endcase
	endfunction

	// Random pair biased toward shared points, collinear and axis-aligned cases.
	function automatic seg_pair_t rand_pair();
		seg_pair_t p;
		int mode, shape;
		coord_t kx, ky;
		mode = $urandom_range(9) < 6 ? 1 : ($urandom_range(9) == 0 ? 2 : 0);
		p.ax = rand_coord(mode); p.ay = rand_coord(mode);
		p.bx = rand_coord(mode); p.by = rand_coord(mode);
		p.cx = rand_coord(mode); p.cy = rand_coord(mode);
		p.dx = rand_coord(mode); p.dy = rand_coord(mode);
		shape = $urandom_range(7);
		case (shape)
			0: begin p.cx = p.bx; p.cy = p.by; end
			1: begin p.bx = p.ax; p.by = p.ay; end
			2: begin p.dx = p.cx; p.dy = p.cy; end
			3: begin
				// collinear: all points on A + m*(kx,ky)
				kx = rand_coord(1); ky = rand_coord(1);
				p.bx = p.ax + kx; p.by = p.ay + ky;
				p.cx = p.ax + kx + kx; p.cy = p.ay + ky + ky;
				p.dx = p.ax - kx; p.dy = p.ay - ky;
				if ($urandom_range(1)) begin p.cx = p.ax - kx; p.cy = p.ay - ky;
					p.dx = p.ax + kx + kx + kx; p.dy = p.ay + ky + ky + ky; end
			end
			4: begin p.bx = p.ax; p.dx = p.cx; end
			5: begin p.by = p.ay; p.dy = p.cy; p.cy = p.ay; end
			default: ;
		endcase
		return p;
	endfunction

	function automatic seg_pair_t mk(int ax, int ay, int bx, int by, int cx, int cy,
		int dx, int dy);
		seg_pair_t p;
		p.ax = coord_t'(ax); p.ay = coord_t'(ay);
		p.bx = coord_t'(bx); p.by = coord_t'(by);
		p.cx = coord_t'(cx); p.cy = coord_t'(cy);
		p.dx = coord_t'(dx); p.dy = coord_t'(dy);
		return p;
	endfunction

	initial begin
		seg_pair_t directed[$];
		int phase;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: every class and each special case.
		directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk(2, 2, 2, 2, 0, 0, 0, 4));
		directed.push_back(mk(0, 4, 0, 4, 0, 0, 0, 4));
		directed.push_back(mk(1, 0, 1, 0, 0, 0, 4, 0));
		directed.push_back(mk(2, 2, 2, 2, 0, 0, 4, 4));
		directed.push_back(mk(0, 0, 4, 4, 4, 4, 4, 4));
		directed.push_back(mk(5, 5, 5, 5, 0, 0, 4, 4));
		directed.push_back(mk(0, 0, 4, 4, 1, 0, 5, 4));
		directed.push_back(mk(0, 0, 4, 0, 4, 0, 8, 0));
		directed.push_back(mk(0, 0, 4, 0, 2, 0, 8, 0));
		directed.push_back(mk(0, 0, 4, 0, 5, 0, 8, 0));
		directed.push_back(mk(0, 0, 0, 4, 0, 0, 0, -4));
		directed.push_back(mk(0, 1, 0, 4, 0, 3, 0, 8));
		directed.push_back(mk(0, 1, 0, 4, 0, 4, 0, 8));
		directed.push_back(mk(0, 0, 2, 2, 2, 2, 4, 4));
		directed.push_back(mk(0, 0, 4, 4, 2, 2, 6, 6));
		directed.push_back(mk(0, 0, 2, 2, 3, 3, 6, 6));
		directed.push_back(mk(0, 0, 4, 4, 0, 4, 4, 0));
		directed.push_back(mk(0, 0, 4, 0, 2, 0, 2, 4));
		directed.push_back(mk(0, 0, 4, 0, 4, 0, 4, 4));
		directed.push_back(mk(0, 0, 4, 0, 5, 1, 5, 4));
		directed.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
		directed.push_back(mk(32767, 32767, 32767, 32767, -32768, -32768, 32767, 32767));
		directed.push_back(mk(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
		foreach (directed[i]) send_pair(directed[i]);

		// Random: sender idling 28%, then heavy idling, then back to back.
		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 28 : (phase == 1 ? 86 : 0);
			repeat (610) send_pair(rand_pair());
			// hold off until every expected word has come back
			drain_all();
		end

		drain_all();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

@@ files.f @@
+incdir+sv
sv/sic_pkg.sv
sv/sic_front.sv
sv/sic_back.sv
sv/segment_intersection_classifier_unit.sv
bench/tb_segment_intersection_classifier_unit.sv
